>>> src/assert_macros.svh
// assertion helpers, clocked on i_clk and disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ab_blit_pkg.sv
package ab_blit_pkg;

    localparam int DEF_PANEL_WIDTH  = 32;
    localparam int DEF_PANEL_HEIGHT = 8;
    localparam int QUEUE_DEPTH      = 4;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int POS_W      = 7;
    localparam int PIX_W      = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_BACKGROUND   = 3'd4;

    localparam logic [1:0] REQ_PIXEL = 2'd0;
    localparam logic [1:0] REQ_FILL  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [POS_W-1:0] RST_IMAGE_WIDTH  = 7'd8;
    localparam logic [POS_W-1:0] RST_IMAGE_HEIGHT = 7'd8;

    typedef enum logic [1:0] {
        CMD_PIXEL,
        CMD_FILL,
        CMD_READ
    } t_cmd_kind;

    // one queued command; data is the rgba pixel or the fill colour
    typedef struct packed {
        t_cmd_kind          kind;
        logic               zero;
        logic [PIX_W-1:0]   data;
    } t_cmd;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_PIX_MUL,
        BE_PIX_WR,
        BE_FILL,
        BE_RD_WAIT
    } t_be_state;

    // floor(x / 255) for x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

>>> src/ab_blit_front.sv
module ab_blit_front #(
    parameter int PANEL_WIDTH  = ab_blit_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = ab_blit_pkg::DEF_PANEL_HEIGHT,
    parameter int ADDR_W       = $clog2(PANEL_WIDTH * PANEL_HEIGHT)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [39:0]                         i_s_tdata,
    input  logic [2:0]                          i_s_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ab_blit_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [ab_blit_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                i_full,
    output logic                                o_push,
    output ab_blit_pkg::t_cmd                   o_push_cmd,
    output logic [ADDR_W-1:0]                   o_push_addr
);

    localparam int PW = ab_blit_pkg::POS_W;

    logic [PW-1:0]  r_origin_x;
    logic [PW-1:0]  r_origin_y;
    logic [PW-1:0]  r_width;
    logic [PW-1:0]  r_height;
    logic [31:0]    r_background;
    logic [PW-1:0]  r_col;
    logic [PW-1:0]  r_row;
    logic [PW-1:0]  n_col;
    logic [PW-1:0]  n_row;

    logic           accept;
    logic [1:0]     req;
    logic           first;
    logic [PW-1:0]  cur_col;
    logic [PW-1:0]  cur_row;
    logic           active;
    logic [8:0]     pos_x;
    logic [8:0]     pos_y;
    logic           on_panel;
    logic [4:0]     rd_col;
    logic [2:0]     rd_row;
    logic           rd_in_range;

    assign o_s_tready  = !i_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_s_tvalid && o_s_tready;
    assign req         = i_s_tuser[1:0];
    assign first       = i_s_tuser[2];
    assign rd_col      = i_s_tdata[36:32];
    assign rd_row      = i_s_tdata[39:37];

    assign cur_col = first ? '0 : r_col;
    assign cur_row = first ? '0 : r_row;
    assign active  = (r_width != '0) && (r_height != '0) && (cur_row < r_height);

    // signed origin plus unsigned position, nine bits cover -64 .. 190
    assign pos_x = {{2{r_origin_x[PW-1]}}, r_origin_x} + {2'b00, cur_col};
    assign pos_y = {{2{r_origin_y[PW-1]}}, r_origin_y} + {2'b00, cur_row};
    assign on_panel = !pos_x[8] && !pos_y[8]
                   && (32'(pos_x[7:0]) < PANEL_WIDTH)
                   && (32'(pos_y[7:0]) < PANEL_HEIGHT);

    assign rd_in_range = (32'(rd_col) < PANEL_WIDTH) && (32'(rd_row) < PANEL_HEIGHT);

    always_comb begin
        n_col = cur_col + 7'd1;
        n_row = cur_row;
        if (n_col >= r_width) begin
            n_col = '0;
            n_row = cur_row + 7'd1;
        end
    end

    always_comb begin
        o_push           = 1'b0;
        o_push_cmd.kind  = ab_blit_pkg::CMD_PIXEL;
        o_push_cmd.zero  = 1'b0;
        o_push_cmd.data  = i_s_tdata[31:0];
        o_push_addr      = '0;
        unique case (req)
            ab_blit_pkg::REQ_PIXEL: begin
                o_push      = accept && active && on_panel;
                o_push_addr = ADDR_W'(32'(pos_y[7:0]) * PANEL_WIDTH + 32'(pos_x[7:0]));
            end
            ab_blit_pkg::REQ_FILL: begin
                o_push          = accept;
                o_push_cmd.kind = ab_blit_pkg::CMD_FILL;
                o_push_cmd.data = r_background;
            end
            ab_blit_pkg::REQ_READ: begin
                o_push          = accept;
                o_push_cmd.kind = ab_blit_pkg::CMD_READ;
                o_push_cmd.zero = !rd_in_range;
                if (rd_in_range) begin
                    o_push_addr = ADDR_W'(32'(rd_row) * PANEL_WIDTH + 32'(rd_col));
                end
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept && (req == ab_blit_pkg::REQ_PIXEL)) begin
            if (active) begin
                r_col <= n_col;
                r_row <= n_row;
            end else begin
                r_col <= cur_col;
                r_row <= cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_width      <= ab_blit_pkg::RST_IMAGE_WIDTH;
            r_height     <= ab_blit_pkg::RST_IMAGE_HEIGHT;
            r_background <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                ab_blit_pkg::CFG_ORIGIN_X:     r_origin_x   <= i_cfg_data[PW-1:0];
                ab_blit_pkg::CFG_ORIGIN_Y:     r_origin_y   <= i_cfg_data[PW-1:0];
                ab_blit_pkg::CFG_IMAGE_WIDTH:  r_width      <= i_cfg_data[PW-1:0];
                ab_blit_pkg::CFG_IMAGE_HEIGHT: r_height     <= i_cfg_data[PW-1:0];
                ab_blit_pkg::CFG_BACKGROUND:   r_background <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

>>> src/ab_blit_queue.sv
module ab_blit_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_head
);

    localparam int DEPTH = ab_blit_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> src/ab_blit_back.sv
`include "assert_macros.svh"

module ab_blit_back #(
    parameter int PANEL_WIDTH  = ab_blit_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = ab_blit_pkg::DEF_PANEL_HEIGHT,
    parameter int ADDR_W       = $clog2(PANEL_WIDTH * PANEL_HEIGHT)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_head_valid,
    input  ab_blit_pkg::t_cmd   i_head_cmd,
    input  logic [ADDR_W-1:0]   i_head_addr,
    output logic                o_pop,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [31:0]         o_m_tdata
);

    localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT;

    logic [31:0]             r_frame [DEPTH];
    logic [31:0]             r_rd_data;
    ab_blit_pkg::t_be_state  r_state;
    ab_blit_pkg::t_be_state  n_state;
    logic [ADDR_W-1:0]       r_addr;
    logic [31:0]             r_data;
    logic                    r_zero;
    logic [ADDR_W-1:0]       r_fill_cnt;
    logic [15:0]             r_sum_r;
    logic [15:0]             r_sum_g;
    logic [15:0]             r_sum_b;
    logic                    r_m_valid;
    logic [31:0]             r_m_data;

    logic                    mem_re;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_wa;
    logic [31:0]             mem_wd;
    logic                    fill_done;
    logic [7:0]              inv_a;

    assign fill_done  = (r_fill_cnt == ADDR_W'(DEPTH - 1));
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign inv_a      = 8'd255 - r_data[31:24];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ab_blit_pkg::BE_IDLE: begin
                if (i_head_valid) begin
                    unique case (i_head_cmd.kind)
                        ab_blit_pkg::CMD_PIXEL: n_state = ab_blit_pkg::BE_PIX_MUL;
                        ab_blit_pkg::CMD_FILL:  n_state = ab_blit_pkg::BE_FILL;
                        ab_blit_pkg::CMD_READ: begin
                            if (!r_m_valid) begin
                                n_state = ab_blit_pkg::BE_RD_WAIT;
                            end
                        end
                        default: n_state = ab_blit_pkg::BE_IDLE;
                    endcase
                end
            end
            ab_blit_pkg::BE_PIX_MUL: n_state = ab_blit_pkg::BE_PIX_WR;
            ab_blit_pkg::BE_PIX_WR:  n_state = ab_blit_pkg::BE_IDLE;
            ab_blit_pkg::BE_FILL: begin
                if (fill_done) begin
                    n_state = ab_blit_pkg::BE_IDLE;
                end
            end
            ab_blit_pkg::BE_RD_WAIT: n_state = ab_blit_pkg::BE_IDLE;
            default: n_state = ab_blit_pkg::BE_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop  = 1'b0;
        mem_re = 1'b0;
        mem_we = 1'b0;
        mem_wa = r_addr;
        mem_wd = {r_rd_data[31:24], ab_blit_pkg::div255(r_sum_b),
                  ab_blit_pkg::div255(r_sum_g), ab_blit_pkg::div255(r_sum_r)};
        unique case (r_state)
            ab_blit_pkg::BE_IDLE: begin
                if (i_head_valid) begin
                    unique case (i_head_cmd.kind)
                        ab_blit_pkg::CMD_PIXEL: begin
                            o_pop  = 1'b1;
                            mem_re = 1'b1;
                        end
                        ab_blit_pkg::CMD_FILL: begin
                            o_pop = 1'b1;
                        end
                        ab_blit_pkg::CMD_READ: begin
                            o_pop  = !r_m_valid;
                            mem_re = !r_m_valid;
                        end
                        default: begin
                            o_pop = 1'b0;
                        end
                    endcase
                end
            end
            ab_blit_pkg::BE_PIX_WR: begin
                mem_we = 1'b1;
            end
            ab_blit_pkg::BE_FILL: begin
                mem_we = 1'b1;
                mem_wa = r_fill_cnt;
                mem_wd = r_data;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_frame[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_frame[i_head_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ab_blit_pkg::BE_IDLE;
            r_fill_cnt <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ab_blit_pkg::BE_FILL) begin
                r_fill_cnt <= fill_done ? '0 : r_fill_cnt + 1'b1;
            end
            if (r_state == ab_blit_pkg::BE_RD_WAIT) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_addr <= i_head_addr;
            r_data <= i_head_cmd.data;
            r_zero <= i_head_cmd.zero;
        end
        // src*a + dst*(255-a) per colour channel
        if (r_state == ab_blit_pkg::BE_PIX_MUL) begin
            r_sum_r <= 16'(r_data[7:0])   * 16'(r_data[31:24])
                     + 16'(r_rd_data[7:0])   * 16'(inv_a);
            r_sum_g <= 16'(r_data[15:8])  * 16'(r_data[31:24])
                     + 16'(r_rd_data[15:8])  * 16'(inv_a);
            r_sum_b <= 16'(r_data[23:16]) * 16'(r_data[31:24])
                     + 16'(r_rd_data[23:16]) * 16'(inv_a);
        end
        if (r_state == ab_blit_pkg::BE_RD_WAIT) begin
            r_m_data <= r_zero ? '0 : r_rd_data;
        end
    end

    `AB_ASSERT_IMP(a_no_result_overwrite, r_state == ab_blit_pkg::BE_RD_WAIT, !r_m_valid, "result register overwritten while still pending")
    `AB_ASSERT_NXT(a_pixel_to_mul, o_pop && (i_head_cmd.kind == ab_blit_pkg::CMD_PIXEL), r_state == ab_blit_pkg::BE_PIX_MUL, "pixel command did not start its blend")
    `AB_ASSERT_IMP(a_write_owner, mem_we, (r_state == ab_blit_pkg::BE_PIX_WR) || (r_state == ab_blit_pkg::BE_FILL), "frame store written outside blend or fill")
    `AB_ASSERT_IMP(a_fill_cnt_idle, r_state != ab_blit_pkg::BE_FILL, r_fill_cnt == '0, "fill counter not at zero outside a fill")

endmodule

>>> src/alpha_blend_image_blitter.sv
// a read result passes the queue, the frame store read and the result register, waiting
// while earlier commands are queued, the back end is busy or the result is still pending
// a pixel is a store read, a multiply and a write back; a read is a store read then
// a result load; pixels off the panel are dropped at the front; requests queue meanwhile
// a fill dequeues, then writes every store entry in turn, one entry per cycle
// reset (synchronous, active low) clears position, queue and control; store is undefined
module alpha_blend_image_blitter #(
    parameter int PANEL_WIDTH  = ab_blit_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = ab_blit_pkg::DEF_PANEL_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // src_red, src_green, src_blue, src_alpha, read_col, read_row
    input  logic [39:0]                         i_s_tdata,
    // req_type, first_pixel
    input  logic [2:0]                          i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [31:0]                         o_m_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ab_blit_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [ab_blit_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int ADDR_W = $clog2(PANEL_WIDTH * PANEL_HEIGHT);
    localparam int Q_W    = $bits(ab_blit_pkg::t_cmd) + ADDR_W;

    logic                 push;
    ab_blit_pkg::t_cmd    push_cmd;
    logic [ADDR_W-1:0]    push_addr;
    logic                 full;
    logic                 pop;
    logic                 head_valid;
    logic [Q_W-1:0]       head;
    ab_blit_pkg::t_cmd    head_cmd;
    logic [ADDR_W-1:0]    head_addr;

    assign head_cmd  = head[Q_W-1:ADDR_W];
    assign head_addr = head[ADDR_W-1:0];

    ab_blit_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_full       (full),
        .o_push       (push),
        .o_push_cmd   (push_cmd),
        .o_push_addr  (push_addr)
    );

    ab_blit_queue #(
        .DATA_W       (Q_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  ({push_cmd, push_addr}),
        .o_full       (full),
        .i_pop        (pop),
        .o_valid      (head_valid),
        .o_head       (head)
    );

    ab_blit_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .ADDR_W       (ADDR_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_cmd   (head_cmd),
        .i_head_addr  (head_addr),
        .o_pop        (pop),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata)
    );

endmodule
